>>> rtl/core/nsaf_pkg.sv
// shared types and constants of the nearest segment attraction field block
package nsaf_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;

   localparam logic [12:0] INPUT_WIDTH_RST   = 13'd512;
   localparam logic [12:0] INPUT_HEIGHT_RST  = 13'd512;
   localparam logic [12:0] OUTPUT_WIDTH_RST  = 13'd128;
   localparam logic [12:0] OUTPUT_HEIGHT_RST = 13'd128;
   localparam logic [6:0]  SEGMENT_COUNT_RST = 7'd0;

   localparam logic [33:0] LN2_Q32 = 34'd2977044472;
   localparam logic [63:0] EPS_Q32 = 64'd4295;

   typedef enum logic [2:0] {
      CSR_INPUT_WIDTH   = 3'd0,
      CSR_INPUT_HEIGHT  = 3'd1,
      CSR_OUTPUT_WIDTH  = 3'd2,
      CSR_OUTPUT_HEIGHT = 3'd3,
      CSR_SEGMENT_COUNT = 3'd4
   } csr_index_type;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic        start;
      logic [6:0]  steps;
      logic [63:0] rem_init;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;

endpackage

>>> rtl/core/nsaf_div.sv
// shift and subtract divider, one quotient bit per cycle
module nsaf_div
   import nsaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [63:0] rem_ff, num_ff, den_ff, quo_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [64:0] sh, diff;
   logic        ge;

   always_comb begin
      sh   = {rem_ff, num_ff[63]};
      ge   = sh >= {1'b0, den_ff};
      diff = sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem_init;
         num_ff <= req.num;
         den_ff <= req.den;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[63:0] : sh[63:0];
         num_ff <= {num_ff[62:0], 1'b0};
         quo_ff <= {quo_ff[62:0], ge};
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

>>> rtl/core/nearest_segment_attraction_field.sv
// top level: segment store, search sequencer, shared multiplier and divider
// query time grows with the N searched segments and is set mostly by the bit-serial
// divider (four 30-step rescales and at most one 16-step projection per segment, two
// 60-step normalizations) and the 16-step log squaring loop
// throughput: one item at a time; the next item is taken once the result is registered
// reset: synchronous, active high; control and CSR registers reset, the store is not cleared
module nearest_segment_attraction_field
   import nsaf_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // segment_index, start_x, start_y, end_x, end_y, pixel_x, pixel_y, zero pad
   input  logic [95:0] req_tdata,
   // command
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // offset_x, offset_y, nearest_label, zero pad
   output logic [39:0] rsp_tdata,
   // found
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int KW = (CW > 7) ? CW : 7;

   typedef enum logic [26:0] {
      S_IDLE  = 27'd1 << 0,  S_RD    = 27'd1 << 1,  S_SMUL  = 27'd1 << 2,
      S_SDIV  = 27'd1 << 3,  S_SWAIT = 27'd1 << 4,  S_DIFF  = 27'd1 << 5,
      S_L1    = 27'd1 << 6,  S_L2    = 27'd1 << 7,  S_D1    = 27'd1 << 8,
      S_D2    = 27'd1 << 9,  S_TSUM  = 27'd1 << 10, S_TDEC  = 27'd1 << 11,
      S_TWAIT = 27'd1 << 12, S_O1    = 27'd1 << 13, S_O2    = 27'd1 << 14,
      S_O3    = 27'd1 << 15, S_O4    = 27'd1 << 16, S_Q1    = 27'd1 << 17,
      S_Q2    = 27'd1 << 18, S_Q3    = 27'd1 << 19, S_LX    = 27'd1 << 20,
      S_LWAIT = 27'd1 << 21, S_NORM  = 27'd1 << 22, S_SQ    = 27'd1 << 23,
      S_SQ2   = 27'd1 << 24, S_LN    = 27'd1 << 25, S_DONE  = 27'd1 << 26
   } state_type;

   state_type state_ff, state_in;

   logic [12:0] iw_ff, ih_ff, ow_ff, oh_ff;
   logic [6:0]  segcnt_ff;
   logic [63:0] mem_ff [MAX_SEGMENTS];
   logic [63:0] seg_ff;

   logic [CW-1:0] i_ff, count_ff;
   logic [1:0]    k_ff;
   logic [15:0]   px_ff, py_ff;
   logic [28:0]   sc_ff [4];
   logic signed [29:0] dx_ff, dy_ff, rx_ff, ry_ff;
   logic signed [63:0] acc_ff, len2_ff, dot_ff;
   logic [16:0]   t_ff;
   logic signed [31:0] rnd_ff, ox_ff, oy_ff, bx_ff, by_ff;
   logic [63:0]   best_ff, z_ff;
   logic          found_ff, axis_ff, l2neg_ff, ln_wait_ff;
   logic [5:0]    label_ff, n_ff;
   logic [31:0]   m_ff;
   logic [15:0]   frac_ff, offx_ff, offy_ff;
   logic [3:0]    it_ff;
   logic signed [67:0] prod_ff;
   logic          rsp_valid_ff, rsp_found_ff;
   logic [39:0]   rsp_data_ff;

   logic signed [33:0] mult_a, mult_b;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        accept;
   logic [12:0] num_sel, den_sel, size_sel;
   logic [15:0] coord_sel;
   logic [29:0] scale_val;
   logic signed [31:0] d_sel;
   logic [31:0] d_mag;
   logic signed [63:0] dot_sum, dis_sum;
   logic [63:0] len2_sum;
   logic [63:0] dis;
   logic [32:0] sq;
   logic [6:0]  nm32;
   logic signed [22:0] l2;
   logic [22:0] lmag;
   logic [16:0] lm;
   logic signed [17:0] v18;
   logic [15:0] vsat;
   logic [KW-1:0] segcnt_ext;
   logic        out_free;

   function automatic logic signed [31:0] round16(input logic signed [67:0] v);
      logic [67:0] mag;
      logic [67:0] r;
      logic [31:0] r32;
      mag = v[67] ? 68'(-v) : 68'(v);
      r   = (mag + 68'd32768) >> 16;
      r32 = r[31:0];
      return v[67] ? $signed(~r32 + 32'd1) : $signed(r32);
   endfunction

   nsaf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign segcnt_ext = KW'(segcnt_ff);

   always_comb begin
      num_sel   = k_ff[0] ? oh_ff : ow_ff;
      den_sel   = k_ff[0] ? ((ih_ff == '0) ? 13'd1 : ih_ff) : ((iw_ff == '0) ? 13'd1 : iw_ff);
      coord_sel = seg_ff[16*k_ff +: 16];
      scale_val = 30'(prod_ff[28:0]) + 30'(den_sel >> 1);
      d_sel     = axis_ff ? by_ff : bx_ff;
      d_mag     = d_sel[31] ? 32'(-d_sel) : 32'(d_sel);
      size_sel  = axis_ff ? ((oh_ff == '0) ? 13'd1 : oh_ff) : ((ow_ff == '0) ? 13'd1 : ow_ff);
      len2_sum  = 64'(acc_ff) + 64'(prod_ff[63:0]);
      dot_sum   = acc_ff + $signed(prod_ff[63:0]);
      dis_sum   = acc_ff + $signed(prod_ff[63:0]);
      dis       = 64'(dis_sum);
      sq        = prod_ff[63:31];
      nm32      = {1'b0, n_ff} - 7'd32;
      l2        = $signed({nm32, frac_ff});
      lmag      = l2[22] ? 23'(-l2) : 23'(l2);
      lm        = 17'((prod_ff[53:0] + 54'(64'd1 << 36)) >> 37);
      v18       = (l2neg_ff ^ !d_sel[31]) ? -$signed({1'b0, lm}) : $signed({1'b0, lm});
      if (v18 > 18'sd32767) begin
         vsat = 16'h7fff;
      end else if (v18 < -18'sd32768) begin
         vsat = 16'h8000;
      end else begin
         vsat = v18[15:0];
      end
   end

   always_comb begin
      mult_a = '0;
      mult_b = '0;
      unique case (state_ff)
         S_SMUL: begin
            mult_a = 34'(coord_sel);
            mult_b = 34'(num_sel);
         end
         S_L1: begin
            mult_a = 34'(dx_ff);
            mult_b = 34'(dx_ff);
         end
         S_L2: begin
            mult_a = 34'(dy_ff);
            mult_b = 34'(dy_ff);
         end
         S_D1: begin
            mult_a = 34'(rx_ff);
            mult_b = 34'(dx_ff);
         end
         S_D2: begin
            mult_a = 34'(ry_ff);
            mult_b = 34'(dy_ff);
         end
         S_O1: begin
            mult_a = 34'(t_ff);
            mult_b = 34'(dx_ff);
         end
         S_O2: begin
            mult_a = 34'(t_ff);
            mult_b = 34'(dy_ff);
         end
         S_Q1: begin
            mult_a = 34'(ox_ff);
            mult_b = 34'(ox_ff);
         end
         S_Q2: begin
            mult_a = 34'(oy_ff);
            mult_b = 34'(oy_ff);
         end
         S_SQ: begin
            mult_a = 34'(m_ff);
            mult_b = 34'(m_ff);
         end
         S_LN: begin
            mult_a = 34'(lmag);
            mult_b = LN2_Q32;
         end
         default: begin
            mult_a = '0;
            mult_b = '0;
         end
      endcase
   end

   always_comb begin
      div_req       = '0;
      div_req.start = 1'b0;
      unique case (state_ff)
         S_SDIV: begin
            div_req.start = 1'b1;
            div_req.steps = 7'd30;
            div_req.num   = {scale_val, 34'd0};
            div_req.den   = 64'(den_sel);
         end
         S_TDEC: begin
            div_req.start    = !(len2_ff == '0 || dot_ff <= 0 || dot_ff >= len2_ff);
            div_req.steps    = 7'd16;
            div_req.rem_init = 64'(dot_ff);
            div_req.den      = 64'(len2_ff);
         end
         S_LX: begin
            div_req.start = 1'b1;
            div_req.steps = 7'd60;
            div_req.num   = {d_mag, 32'd0};
            div_req.den   = 64'(size_sel);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser == CMD_QUERY) begin
               state_in = (segcnt_ff == '0) ? S_DONE : S_RD;
            end
         end
         S_RD:    state_in = S_SMUL;
         S_SMUL:  state_in = S_SDIV;
         S_SDIV:  state_in = S_SWAIT;
         S_SWAIT: begin
            if (div_rsp.done) begin
               state_in = (k_ff == 2'd3) ? S_DIFF : S_SMUL;
            end
         end
         S_DIFF:  state_in = S_L1;
         S_L1:    state_in = S_L2;
         S_L2:    state_in = S_D1;
         S_D1:    state_in = S_D2;
         S_D2:    state_in = S_TSUM;
         S_TSUM:  state_in = S_TDEC;
         S_TDEC:  state_in = div_req.start ? S_TWAIT : S_O1;
         S_TWAIT: begin
            if (div_rsp.done) begin
               state_in = S_O1;
            end
         end
         S_O1:    state_in = S_O2;
         S_O2:    state_in = S_O3;
         S_O3:    state_in = S_O4;
         S_O4:    state_in = S_Q1;
         S_Q1:    state_in = S_Q2;
         S_Q2:    state_in = S_Q3;
         S_Q3:    state_in = (i_ff + CW'(1) == count_ff) ? S_LX : S_RD;
         S_LX:    state_in = S_LWAIT;
         S_LWAIT: begin
            if (div_rsp.done) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (z_ff[63]) begin
               state_in = S_SQ;
            end
         end
         S_SQ:    state_in = S_SQ2;
         S_SQ2:   state_in = (it_ff == 4'd15) ? S_LN : S_SQ;
         // multiplies first, then stores the offset from the registered product
         S_LN: begin
            if (ln_wait_ff) begin
               state_in = axis_ff ? S_DONE : S_LX;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ln_wait_ff <= 1'b0;
      end else begin
         ln_wait_ff <= (state_ff == S_LN) && !ln_wait_ff;
         state_ff   <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff     <= INPUT_WIDTH_RST;
         ih_ff     <= INPUT_HEIGHT_RST;
         ow_ff     <= OUTPUT_WIDTH_RST;
         oh_ff     <= OUTPUT_HEIGHT_RST;
         segcnt_ff <= SEGMENT_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INPUT_WIDTH:   iw_ff     <= csr_wdata;
            CSR_INPUT_HEIGHT:  ih_ff     <= csr_wdata;
            CSR_OUTPUT_WIDTH:  ow_ff     <= csr_wdata;
            CSR_OUTPUT_HEIGHT: oh_ff     <= csr_wdata;
            CSR_SEGMENT_COUNT: segcnt_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_LOAD && 32'(req_tdata[5:0]) < MAX_SEGMENTS) begin
         mem_ff[IW'(req_tdata[5:0])] <= req_tdata[69:6];
      end
      if (state_ff == S_RD) begin
         seg_ff <= mem_ff[i_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_IDLE && accept && req_tuser == CMD_QUERY) begin
            found_ff <= 1'b0;
         end
         if (state_ff == S_Q3 && (!found_ff || dis < best_ff)) begin
            found_ff <= 1'b1;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mult_a * mult_b;
      unique case (state_ff)
         S_IDLE: begin
            px_ff    <= {req_tdata[81:70], 4'd0};
            py_ff    <= {req_tdata[93:82], 4'd0};
            i_ff     <= '0;
            k_ff     <= '0;
            label_ff <= '0;
            best_ff  <= '0;
            axis_ff  <= 1'b0;
            if (segcnt_ext > KW'(MAX_SEGMENTS)) begin
               count_ff <= CW'(MAX_SEGMENTS);
            end else begin
               count_ff <= CW'(segcnt_ff);
            end
         end
         S_RD: k_ff <= '0;
         S_SWAIT: begin
            if (div_rsp.done) begin
               sc_ff[k_ff] <= div_rsp.quo[28:0];
               k_ff        <= k_ff + 2'd1;
            end
         end
         S_DIFF: begin
            dx_ff <= $signed({1'b0, sc_ff[2]}) - $signed({1'b0, sc_ff[0]});
            dy_ff <= $signed({1'b0, sc_ff[3]}) - $signed({1'b0, sc_ff[1]});
            rx_ff <= $signed({14'd0, px_ff}) - $signed({1'b0, sc_ff[0]});
            ry_ff <= $signed({14'd0, py_ff}) - $signed({1'b0, sc_ff[1]});
         end
         S_L2:   acc_ff  <= prod_ff[63:0];
         S_D1:   len2_ff <= $signed(len2_sum);
         S_D2:   acc_ff  <= prod_ff[63:0];
         S_TSUM: dot_ff  <= dot_sum;
         S_TDEC: begin
            if (len2_ff == '0 || dot_ff <= 0) begin
               t_ff <= '0;
            end else begin
               t_ff <= 17'h10000;
            end
         end
         S_TWAIT: begin
            if (div_rsp.done) begin
               t_ff <= {1'b0, div_rsp.quo[15:0]};
            end
         end
         S_O2: rnd_ff <= round16(prod_ff);
         S_O3: begin
            ox_ff  <= $signed({3'd0, sc_ff[0]}) - $signed({16'd0, px_ff}) + rnd_ff;
            rnd_ff <= round16(prod_ff);
         end
         S_O4: oy_ff  <= $signed({3'd0, sc_ff[1]}) - $signed({16'd0, py_ff}) + rnd_ff;
         S_Q2: acc_ff <= prod_ff[63:0];
         S_Q3: begin
            if (!found_ff || dis < best_ff) begin
               best_ff  <= dis;
               label_ff <= 6'(i_ff);
               bx_ff    <= ox_ff;
               by_ff    <= oy_ff;
            end
            i_ff <= i_ff + CW'(1);
         end
         S_LWAIT: begin
            z_ff <= div_rsp.quo + EPS_Q32;
            n_ff <= 6'd63;
         end
         S_NORM: begin
            if (z_ff[63]) begin
               m_ff    <= z_ff[63:32];
               it_ff   <= '0;
               frac_ff <= '0;
            end else begin
               z_ff <= {z_ff[62:0], 1'b0};
               n_ff <= n_ff - 6'd1;
            end
         end
         S_SQ2: begin
            if (sq[32]) begin
               m_ff    <= sq[32:1];
               frac_ff <= {frac_ff[14:0], 1'b1};
            end else begin
               m_ff    <= sq[31:0];
               frac_ff <= {frac_ff[14:0], 1'b0};
            end
            it_ff <= it_ff + 4'd1;
         end
         S_LN: begin
            if (!ln_wait_ff) begin
               l2neg_ff <= l2[22];
            end else begin
               if (axis_ff) begin
                  offy_ff <= vsat;
               end else begin
                  offx_ff <= vsat;
               end
               axis_ff <= 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_found_ff <= found_ff;
               rsp_data_ff  <= found_ff ? {2'd0, label_ff, offy_ff, offx_ff} : '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

>>> rtl/core/nsaf_checker.sv
// port level checks of the nearest segment attraction field, bound to the top level
module nsaf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a query transfer blocks the input side
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input ready right after query");

   // empty search gives zero payload
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("payload not zero without segment");

   // padding stays clear
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:38] == 2'd0)
      else $error("result pad bits set");

endmodule

bind nearest_segment_attraction_field nsaf_checker u_nsaf_checker (.*);
